>>> rtl/sha512_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-512 package
// Shared types, constants and the rotate function of the SHA-512 engine.
// ----------------------------------------------------------------------------
package sha512_pkg;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  count;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  localparam logic [63:0] INIT_H [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam logic [63:0] ROUND_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [6:0] PAD_LEN_POS = 7'd112;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

endpackage
`default_nettype wire

>>> rtl/sha512_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-512 stream interfaces
// Valid/ready channels for message words and digest words.
// ----------------------------------------------------------------------------
interface sha512_in_if;
  logic                 valid;
  logic                 ready;
  sha512_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sha512_out_if;
  logic                  valid;
  logic                  ready;
  sha512_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/sha512_hash_engine.sv
`default_nettype none
// An item is taken from the queue and its bytes are packed into the block buffer,
// which goes through the round unit each time it is full; the core takes no new
// item until it is through with the last. A final item adds padding (one or two
// blocks) and eight digest transfers, one per cycle while out_ready is high.
// Reset is synchronous and active low and restores the initial hash values.
// ----------------------------------------------------------------------------
// SHA-512 hash engine
// Input queue in front of a byte packer, round unit and digest emitter.
// ----------------------------------------------------------------------------
module sha512_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_message_word,
  input  wire logic [3:0]  in_byte_count,
  input  wire logic        in_final_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  sha512_in_if  in_ch ();
  sha512_in_if  q_ch ();
  sha512_out_if out_ch ();

  assign in_ch.valid = in_valid;
  assign in_ch.payload.word  = in_message_word;
  assign in_ch.payload.count = in_byte_count;
  assign in_ch.payload.last  = in_final_item;
  assign in_ready = in_ch.ready;

  assign out_valid       = out_ch.valid;
  assign out_ch.ready    = out_ready;
  assign out_digest_word = out_ch.payload.digest_word;
  assign out_word_index  = out_ch.payload.word_index;
  assign out_last_word   = out_ch.payload.last_word;

  sha512_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .q_ch  (q_ch.source)
  );

  sha512_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_ch   (q_ch.sink),
    .out_ch (out_ch.source)
  );

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last_word does not match word index");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest words not consecutive");

  a_no_take_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !q_ch.ready)
    else $error("core accepted input while emitting");

endmodule
`default_nettype wire

>>> rtl/sha512_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-512 input queue
// Two-entry queue that decouples word acceptance from the hash core.
// ----------------------------------------------------------------------------
module sha512_queue (
  input  wire logic       clk,
  input  wire logic       rst_n,
  sha512_in_if.sink       in_ch,
  sha512_in_if.source     q_ch
);

  sha512_pkg::in_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign q_ch.valid  = (cnt_r != 2'd0);
  assign q_ch.payload = mem_r[rp_r];
  assign push = in_ch.valid && in_ch.ready;
  assign pop  = q_ch.valid && q_ch.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_ch.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

>>> rtl/sha512_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-512 core
// Packs bytes into the block buffer, pads, runs one round per cycle and
// emits the digest.
// ----------------------------------------------------------------------------
module sha512_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  sha512_in_if.sink       q_ch,
  sha512_out_if.source    out_ch
);

  sha512_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [63:0]  w_r [16];
  logic [63:0]  h_r [8];
  logic [63:0]  v_r [8];
  logic [127:0] bits_r, bits_nxt;
  logic [6:0]   fill_r, fill_nxt;
  logic [6:0]   rnd_r, rnd_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  logic [3:0]   k_r, k_nxt;
  logic [63:0]  word_r, word_nxt;
  logic         last_r, last_nxt;
  logic         marked_r, marked_nxt;
  logic [2:0]   oidx_r, oidx_nxt;

  logic         put_byte, do_round, do_fold, do_len, rearm, start;
  logic [7:0]   byte_val;
  logic [3:0]   sat;
  logic [63:0]  wnew, t1, t2, s0, s1, e, a, rk;
  logic [3:0]   bidx;
  logic [5:0]   bsh;

  assign sat  = (q_ch.payload.count > 4'd8) ? 4'd8 : q_ch.payload.count;
  assign bidx = fill_r[6:3];
  assign bsh  = 6'd56 - {fill_r[2:0], 3'b000};

  assign s0 = sha512_pkg::rotr(w_r[1], 1) ^ sha512_pkg::rotr(w_r[1], 8) ^ (w_r[1] >> 7);
  assign s1 = sha512_pkg::rotr(w_r[14], 19) ^ sha512_pkg::rotr(w_r[14], 61) ^ (w_r[14] >> 6);
  assign wnew = w_r[0] + s0 + w_r[9] + s1;
  assign e  = v_r[4];
  assign a  = v_r[0];
  assign rk = sha512_pkg::ROUND_K[rnd_r];
  assign t1 = v_r[7] + (sha512_pkg::rotr(e, 14) ^ sha512_pkg::rotr(e, 18)
              ^ sha512_pkg::rotr(e, 41)) + ((e & v_r[5]) ^ (~e & v_r[6])) + rk + w_r[0];
  assign t2 = (sha512_pkg::rotr(a, 28) ^ sha512_pkg::rotr(a, 34) ^ sha512_pkg::rotr(a, 39))
              + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));

  assign out_ch.valid = (state_r == sha512_pkg::ST_EMIT);
  assign out_ch.payload.digest_word = h_r[oidx_r];
  assign out_ch.payload.word_index  = oidx_r;
  assign out_ch.payload.last_word   = (oidx_r == 3'd7);
  assign q_ch.ready = (state_r == sha512_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    bits_nxt  = bits_r;
    fill_nxt  = fill_r;
    rnd_nxt   = rnd_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    word_nxt  = word_r;
    last_nxt  = last_r;
    marked_nxt = marked_r;
    oidx_nxt  = oidx_r;
    put_byte  = 1'b0;
    byte_val  = 8'h00;
    do_round  = 1'b0;
    do_fold   = 1'b0;
    do_len    = 1'b0;
    rearm     = 1'b0;
    start     = 1'b0;
    unique case (state_r)
      sha512_pkg::ST_IDLE: begin
        if (q_ch.valid) begin
          word_nxt  = q_ch.payload.word;
          cnt_nxt   = sat;
          last_nxt  = q_ch.payload.last;
          k_nxt     = 4'd0;
          marked_nxt = 1'b0;
          bits_nxt  = bits_r + {121'd0, sat, 3'b000};
          state_nxt = sha512_pkg::ST_FILL;
        end
      end
      sha512_pkg::ST_FILL: begin
        if (k_r == cnt_r) begin
          state_nxt = last_r ? sha512_pkg::ST_PAD : sha512_pkg::ST_IDLE;
        end else begin
          put_byte = 1'b1;
          byte_val = word_r[63:56];
          word_nxt = {word_r[55:0], 8'h00};
          k_nxt    = k_r + 4'd1;
          fill_nxt = fill_r + 7'd1;
          if (fill_r == 7'd127) begin
            start = 1'b1;
            ret_nxt = sha512_pkg::ST_FILL;
            state_nxt = sha512_pkg::ST_ROUND;
          end
        end
      end
      sha512_pkg::ST_PAD: begin
        if (marked_r && fill_r == sha512_pkg::PAD_LEN_POS) begin
          do_len = 1'b1;
          start  = 1'b1;
          fill_nxt = 7'd0;
          ret_nxt = sha512_pkg::ST_EMIT;
          state_nxt = sha512_pkg::ST_ROUND;
        end else begin
          put_byte = 1'b1;
          byte_val = marked_r ? 8'h00 : sha512_pkg::PAD_MARK;
          marked_nxt = 1'b1;
          fill_nxt = fill_r + 7'd1;
          if (fill_r == 7'd127) begin
            start = 1'b1;
            ret_nxt = sha512_pkg::ST_PAD;
            state_nxt = sha512_pkg::ST_ROUND;
          end
        end
      end
      sha512_pkg::ST_ROUND: begin
        do_round = 1'b1;
        rnd_nxt  = rnd_r + 7'd1;
        if (rnd_r == 7'd79) begin
          rnd_nxt   = 7'd0;
          state_nxt = sha512_pkg::ST_FOLD;
        end
      end
      sha512_pkg::ST_FOLD: begin
        do_fold   = 1'b1;
        oidx_nxt  = 3'd0;
        state_nxt = ret_r;
      end
      sha512_pkg::ST_EMIT: begin
        if (out_ch.ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            rearm = 1'b1;
            bits_nxt = 128'd0;
            state_nxt = sha512_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = sha512_pkg::ST_IDLE;
    endcase
    if (start) rnd_nxt = 7'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sha512_pkg::ST_IDLE;
      ret_r    <= sha512_pkg::ST_IDLE;
      bits_r   <= 128'd0;
      fill_r   <= 7'd0;
      rnd_r    <= 7'd0;
      cnt_r    <= 4'd0;
      k_r      <= 4'd0;
      last_r   <= 1'b0;
      marked_r <= 1'b0;
      oidx_r   <= 3'd0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      bits_r   <= bits_nxt;
      fill_r   <= fill_nxt;
      rnd_r    <= rnd_nxt;
      cnt_r    <= cnt_nxt;
      k_r      <= k_nxt;
      last_r   <= last_nxt;
      marked_r <= marked_nxt;
      oidx_r   <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  // The block buffer doubles as the message schedule window during rounds.
  always_ff @(posedge clk) begin
    if (put_byte) begin
      w_r[bidx][bsh +: 8] <= byte_val;
    end else if (do_len) begin
      w_r[14] <= bits_r[127:64];
      w_r[15] <= bits_r[63:0];
    end else if (do_round) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= wnew;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) h_r[i] <= sha512_pkg::INIT_H[i];
    end else if (do_fold) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end else if (rearm) begin
      for (int i = 0; i < 8; i++) h_r[i] <= sha512_pkg::INIT_H[i];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (do_round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

endmodule
`default_nettype wire
